// File: design/mts_pkg.sv
`timescale 1ns / 1ps
// Package for the midtone transfer stretch core: sample width, full scale,
// register indexes and the types shared by the pipeline stages. No dependencies.
package mts_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DIV_W       = 2 * SAMPLE_BITS;
  localparam int ADDR_W      = 4;

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

  typedef enum logic [1:0] {
    REG_SHADOW    = 2'd0,
    REG_HIGHLIGHT = 2'd1,
    REG_MIDTONE   = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] shadow;
    logic [SAMPLE_BITS-1:0] highlight;
    logic [SAMPLE_BITS-1:0] midtone;
  } cfg_t;

  typedef struct packed {
    logic [DIV_W-1:0]       rem;
    logic [DIV_W-1:0]       den;
    logic [DIV_W-1:0]       num;
    logic [SAMPLE_BITS-1:0] quo;
    logic                   flag_lo;
    logic                   flag_hi;
  } div_t;

endpackage

// File: design/mts_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the input and output sample channels.
// Depends on mts_pkg for the sample width.
interface mts_in_if;
  logic                            valid;
  logic                            ready;
  logic [mts_pkg::SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface mts_out_if;
  logic                            valid;
  logic                            ready;
  logic [mts_pkg::SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: design/mts_front.sv
`timescale 1ns / 1ps
// Input stage: offsets the sample into the clip window and sets up the first division.
// Depends on mts_pkg.
module mts_front (
  input  logic                            clk,
  input  logic                            rst,
  input  mts_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mts_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mts_pkg::div_t                   out_data
);
  import mts_pkg::*;

  logic [SAMPLE_BITS-1:0] offset;
  logic [SAMPLE_BITS-1:0] span;
  div_t                   data_next;

  assign in_ready = !out_valid || out_ready;
  assign offset   = in_sample - cfg.shadow;
  assign span     = cfg.highlight - cfg.shadow;

  always_comb begin
    data_next.rem     = DIV_W'(offset);
    data_next.num     = DIV_W'(offset);
    data_next.den     = DIV_W'(span);
    data_next.quo     = '0;
    data_next.flag_lo = (in_sample <= cfg.shadow);
    data_next.flag_hi = (in_sample >= cfg.highlight);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// File: design/mts_div_cell.sv
`timescale 1ns / 1ps
// One restoring division step: shifts the partial remainder and develops one quotient bit.
// Depends on mts_pkg.
module mts_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mts_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mts_pkg::div_t out_data
);
  import mts_pkg::*;

  logic [DIV_W:0] rem_shift;
  logic [DIV_W:0] rem_diff;
  div_t           data_next;

  assign in_ready  = !out_valid || out_ready;
  assign rem_shift = {in_data.rem, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, in_data.den};

  always_comb begin
    data_next = in_data;
    if (rem_shift >= {1'b0, in_data.den}) begin
      data_next.rem = rem_diff[DIV_W-1:0];
      data_next.quo = {in_data.quo[SAMPLE_BITS-2:0], 1'b1};
    end else begin
      data_next.rem = rem_shift[DIV_W-1:0];
      data_next.quo = {in_data.quo[SAMPLE_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// File: design/mts_mid.sv
`timescale 1ns / 1ps
// Middle stages: finishes the clip quotient, forms the transfer numerator and
// denominator products, and sets up the second division. Depends on mts_pkg.
module mts_mid (
  input  logic          clk,
  input  logic          rst,
  input  mts_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  mts_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mts_pkg::div_t out_data
);
  import mts_pkg::*;

  logic                   xc_valid;
  logic                   xc_ready;
  logic [SAMPLE_BITS-1:0] xc;
  logic                   xc_zero;
  logic                   xc_full;
  logic [SAMPLE_BITS-1:0] xc_next;
  logic [SAMPLE_BITS-1:0] quo_fix;

  logic                   prod_valid;
  logic                   prod_ready;
  logic [DIV_W-1:0]       prod_num;
  logic [DIV_W-1:0]       prod_mid;
  logic                   prod_zero;
  logic                   prod_full;
  logic [SAMPLE_BITS-1:0] inv_mid;

  assign in_ready   = !xc_valid || xc_ready;
  assign xc_ready   = !prod_valid || prod_ready;
  assign prod_ready = !out_valid || out_ready;

  // A remainder below the offset means the dividend minus one step drops a unit.
  assign quo_fix = in_data.quo - SAMPLE_BITS'(in_data.rem < in_data.num);

  always_comb begin
    priority if (in_data.flag_lo) begin
      xc_next = '0;
    end else if (in_data.flag_hi) begin
      xc_next = FULL_SCALE;
    end else begin
      xc_next = quo_fix;
    end
  end

  assign inv_mid = FULL_SCALE - cfg.midtone;

  always_ff @(posedge clk) begin
    if (rst) begin
      xc_valid   <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        xc_valid <= in_valid;
      end
      if (xc_ready) begin
        prod_valid <= xc_valid;
      end
      if (prod_ready) begin
        out_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      xc      <= xc_next;
      xc_zero <= in_data.flag_lo;
      xc_full <= in_data.flag_hi;
    end
    if (xc_ready && xc_valid) begin
      prod_num  <= DIV_W'(inv_mid) * DIV_W'(xc);
      prod_mid  <= DIV_W'(cfg.midtone) * DIV_W'(FULL_SCALE - xc);
      prod_zero <= xc_zero;
      prod_full <= xc_full;
    end
    if (prod_ready && prod_valid) begin
      out_data.rem     <= prod_num;
      out_data.num     <= prod_num;
      out_data.den     <= prod_mid + prod_num;
      out_data.quo     <= '0;
      out_data.flag_lo <= prod_zero;
      out_data.flag_hi <= prod_full;
    end
  end

endmodule

// File: design/mts_back.sv
`timescale 1ns / 1ps
// Output stage: finishes the transfer quotient, applies the window and midtone
// end cases and holds the result register. Depends on mts_pkg.
module mts_back (
  input  logic                            clk,
  input  logic                            rst,
  input  mts_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mts_pkg::div_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mts_pkg::SAMPLE_BITS-1:0] out_sample
);
  import mts_pkg::*;

  logic [SAMPLE_BITS-1:0] quo_fix;
  logic [SAMPLE_BITS-1:0] sample_next;

  assign in_ready = !out_valid || out_ready;
  assign quo_fix  = in_data.quo - SAMPLE_BITS'(in_data.rem < in_data.num);

  always_comb begin
    priority if (cfg.highlight <= cfg.shadow) begin
      sample_next = '0;
    end else if (cfg.midtone == '0) begin
      sample_next = '0;
    end else if (cfg.midtone == FULL_SCALE) begin
      sample_next = FULL_SCALE;
    end else if (in_data.flag_hi) begin
      sample_next = FULL_SCALE;
    end else if (in_data.flag_lo) begin
      sample_next = '0;
    end else begin
      sample_next = quo_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_sample <= sample_next;
    end
  end

endmodule

// File: design/midtone_transfer_stretch_core.sv
`timescale 1ns / 1ps
// Midtone transfer stretch core: clips each sample to the shadow/highlight window,
// rescales it to full scale and applies the midtones transfer function.
// Depends on mts_pkg, mts_if, mts_front, mts_div_cell, mts_mid and mts_back.
//
// Samples enter on pixel_in and results leave on pixel_out, both valid/ready
// streams; a transaction completes on a clock edge with valid and ready high.
// The three window and midtone registers sit on an APB-style port at byte
// addresses 0, 4 and 8; the user must write them only while no samples are in
// flight, as the block itself does not enforce this. The datapath is a row of
// elastic stages: one input stage, one restoring division cell per quotient
// bit for the window rescale, three stages for the quotient fix-up and the two
// products, a second row of division cells for the transfer ratio, and the
// output register. Without back-pressure one sample is accepted every cycle.
// Each stage holds its data when the one after it is full, so a stalled
// receiver fills the row back to the input before pixel_in.ready drops.
// Synchronous reset empties every stage and loads the registers with shadow 0,
// highlight full scale and midtone one half.
module midtone_transfer_stretch_core (
  input  logic                       clk,
  input  logic                       rst,
  mts_in_if.sink                     pixel_in,
  mts_out_if.source                  pixel_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mts_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import mts_pkg::*;

  cfg_t       cfg;
  reg_index_t reg_sel;
  logic       reg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[ADDR_W-1:2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shadow    <= '0;
      cfg.highlight <= FULL_SCALE;
      cfg.midtone   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_SHADOW:    cfg.shadow    <= pwdata[SAMPLE_BITS-1:0];
        REG_HIGHLIGHT: cfg.highlight <= pwdata[SAMPLE_BITS-1:0];
        REG_MIDTONE:   cfg.midtone   <= pwdata[SAMPLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SHADOW:    prdata = 32'(cfg.shadow);
      REG_HIGHLIGHT: prdata = 32'(cfg.highlight);
      REG_MIDTONE:   prdata = 32'(cfg.midtone);
      default:       prdata = '0;
    endcase
  end

  logic valid_a [SAMPLE_BITS+1];
  logic ready_a [SAMPLE_BITS+1];
  div_t data_a  [SAMPLE_BITS+1];
  logic valid_b [SAMPLE_BITS+1];
  logic ready_b [SAMPLE_BITS+1];
  div_t data_b  [SAMPLE_BITS+1];

  mts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pixel_in.valid),
    .in_ready  (pixel_in.ready),
    .in_sample (pixel_in.sample_in),
    .out_valid (valid_a[0]),
    .out_ready (ready_a[0]),
    .out_data  (data_a[0])
  );

  for (genvar i = 0; i < SAMPLE_BITS; i++) begin : g_clip_div
    mts_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_a[i]),
      .in_ready  (ready_a[i]),
      .in_data   (data_a[i]),
      .out_valid (valid_a[i+1]),
      .out_ready (ready_a[i+1]),
      .out_data  (data_a[i+1])
    );
  end

  mts_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (valid_a[SAMPLE_BITS]),
    .in_ready  (ready_a[SAMPLE_BITS]),
    .in_data   (data_a[SAMPLE_BITS]),
    .out_valid (valid_b[0]),
    .out_ready (ready_b[0]),
    .out_data  (data_b[0])
  );

  for (genvar i = 0; i < SAMPLE_BITS; i++) begin : g_mtf_div
    mts_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_b[i]),
      .in_ready  (ready_b[i]),
      .in_data   (data_b[i]),
      .out_valid (valid_b[i+1]),
      .out_ready (ready_b[i+1]),
      .out_data  (data_b[i+1])
    );
  end

  mts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (valid_b[SAMPLE_BITS]),
    .in_ready   (ready_b[SAMPLE_BITS]),
    .in_data    (data_b[SAMPLE_BITS]),
    .out_valid  (pixel_out.valid),
    .out_ready  (pixel_out.ready),
    .out_sample (pixel_out.sample_out)
  );

endmodule
